@@ rtl/tcst_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the TCP connection state tracker.
// No dependencies; imported by the top level and the testbench (tcst_ram does not use it).
package tcst_pkg;

	localparam int STREAMS_DEFAULT = 1024;
	localparam int IDX_W           = 10;
	localparam int SEQ_W           = 32;

	// TCP flag bit positions in the flag byte
	localparam int FL_FIN_BIT = 0;
	localparam int FL_SYN_BIT = 1;
	localparam int FL_RST_BIT = 2;
	localparam int FL_ACK_BIT = 4;

	// item operation codes
	localparam logic OP_SEGMENT = 1'b0;
	localparam logic OP_CLEAR   = 1'b1;

	typedef enum logic [2:0] {
		ST_CLOSED      = 3'd0,
		ST_SYN_RCVD    = 3'd1,
		ST_ESTABLISHED = 3'd2,
		ST_FIN_RCVD    = 3'd3,
		ST_CLOSING     = 3'd4
	} conn_state_t;

	// one input item
	typedef struct packed {
		logic             op;
		logic [IDX_W-1:0] stream_index;
		logic             from_client;
		logic [7:0]       tcp_flags;
		logic [SEQ_W-1:0] seq_number;
	} cmd_t;

	// one result item
	typedef struct packed {
		logic [IDX_W-1:0] echo_index;
		logic [2:0]       prior_state;
		logic [2:0]       new_state;
		logic [SEQ_W-1:0] client_initial_seq;
		logic [SEQ_W-1:0] server_initial_seq;
		logic [SEQ_W-1:0] client_expected_seq;
		logic [SEQ_W-1:0] server_expected_seq;
	} result_t;

	// one flow table entry as stored in the RAM
	typedef struct packed {
		conn_state_t      state;
		logic [SEQ_W-1:0] client_init_seq;
		logic [SEQ_W-1:0] server_init_seq;
		logic [SEQ_W-1:0] client_next;
		logic [SEQ_W-1:0] server_next;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ rtl/tcst_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old contents.
module tcst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/tcp_connection_state_tracker_top.sv @@
`timescale 1ns / 1ps
// Top level of the TCP connection state tracker: flow table RAM, update logic.
// Depends on tcst_pkg and tcst_ram.
//
// Usage: after reset, busy stays high while a clearing pass zeroes the flow
// table one entry per cycle. After that, busy stays low and an item is taken
// on every clock edge with start high, one item per cycle. Each item gives
// exactly one result on the result port, with done high for one cycle (the
// flow entry is read from the table RAM through its registered read port,
// then updated, written back and registered as the result). There is no way
// to stall results: the receiver must take every one. Items to the same flow
// in consecutive cycles are handled by forwarding the entry just written. An
// index at or above STREAMS updates nothing and reports zeros but its index.
module tcp_connection_state_tracker_top #(
	parameter int STREAMS = tcst_pkg::STREAMS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tcst_pkg::cmd_t    cmd,
	output logic              done,
	output tcst_pkg::result_t result
);

	import tcst_pkg::*;

	localparam int AW = (STREAMS > 1) ? $clog2(STREAMS) : 1;

	// clearing pass
	logic          clearing_q;
	logic [AW-1:0] clr_cnt_q;

	// compute stage
	logic             v_s1;
	logic             op_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [AW-1:0]    addr_s1;
	logic             client_s1;
	logic [7:0]       flags_s1;
	logic [SEQ_W-1:0] seq_s1;
	logic             range_s1;
	logic             hit_s1;

	// forwarding copy of the last written entry
	entry_t fwd_q;

	// output registers
	logic    done_q;
	result_t result_q;

	logic                accept;
	logic [AW+IDX_W-1:0] idx_ext;
	logic [AW-1:0]       addr_in;
	logic                in_range;
	logic                item_we;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic [ENTRY_W-1:0]  ram_rdata;
	entry_t              cur;
	entry_t              upd;
	logic [SEQ_W-1:0]    seq_p1;
	logic                f_fin;
	logic                f_syn;
	logic                f_rst;
	logic                f_ack;

	assign accept   = start && !clearing_q;
	assign busy     = clearing_q;
	assign idx_ext  = {{AW{1'b0}}, cmd.stream_index};
	assign addr_in  = idx_ext[AW-1:0];
	assign in_range = (32'(cmd.stream_index) < STREAMS);

	// table RAM: clearing pass or write-back of the updated entry
	assign item_we   = v_s1 && range_s1;
	assign ram_we    = clearing_q || item_we;
	assign ram_waddr = clearing_q ? clr_cnt_q : addr_s1;
	assign ram_wdata = clearing_q ? '0 : ENTRY_W'(upd);

	tcst_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(STREAMS),
		.AW   (AW)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr_in),
		.rdata(ram_rdata)
	);

	// entry as seen by this item
	assign cur    = hit_s1 ? fwd_q : entry_t'(ram_rdata);
	assign seq_p1 = seq_s1 + SEQ_W'(1);
	assign f_fin  = flags_s1[FL_FIN_BIT];
	assign f_syn  = flags_s1[FL_SYN_BIT];
	assign f_rst  = flags_s1[FL_RST_BIT];
	assign f_ack  = flags_s1[FL_ACK_BIT];

	// flow update rules
	always_comb begin
		upd = cur;
		if (op_s1 == OP_CLEAR) begin
			upd = '0;
			upd.state = ST_CLOSED;
		end else if (f_rst) begin
			upd.state = ST_CLOSED;
		end else begin
			case (cur.state)
				ST_CLOSED: begin
					if (f_syn && !f_ack && client_s1) begin
						upd.client_init_seq = seq_s1;
						upd.client_next     = seq_p1;
						upd.state           = ST_SYN_RCVD;
					end
				end
				ST_SYN_RCVD: begin
					if (f_syn && f_ack && !client_s1) begin
						upd.server_init_seq = seq_s1;
						upd.server_next     = seq_p1;
						upd.state           = ST_ESTABLISHED;
					end else if (f_syn && client_s1) begin
						upd.client_init_seq = seq_s1;
						upd.client_next     = seq_p1;
					end
				end
				ST_ESTABLISHED: begin
					if (f_fin) begin
						upd.state = ST_FIN_RCVD;
					end
					if (client_s1) begin
						if (seq_s1 >= cur.client_next) begin
							upd.client_next = seq_p1;
						end
					end else begin
						if (seq_s1 >= cur.server_next) begin
							upd.server_next = seq_p1;
						end
					end
				end
				ST_FIN_RCVD: begin
					if (f_fin) begin
						upd.state = ST_CLOSING;
					end
				end
				default: begin
					upd = cur;
				end
			endcase
		end
	end

	// control: clearing pass, stage valid, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
			v_s1       <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (clearing_q) begin
				if (clr_cnt_q == AW'(STREAMS - 1)) begin
					clearing_q <= 1'b0;
				end
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			v_s1   <= accept;
			done_q <= v_s1;
		end
	end

	// payload: stage registers, forwarding copy, result
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= cmd.op;
			idx_s1    <= cmd.stream_index;
			addr_s1   <= addr_in;
			client_s1 <= cmd.from_client;
			flags_s1  <= cmd.tcp_flags;
			seq_s1    <= cmd.seq_number;
			range_s1  <= in_range;
			hit_s1    <= item_we && (addr_s1 == addr_in);
		end
		if (item_we) begin
			fwd_q <= upd;
		end
		if (v_s1) begin
			if (range_s1) begin
				result_q.echo_index          <= idx_s1;
				result_q.prior_state         <= 3'(cur.state);
				result_q.new_state           <= 3'(upd.state);
				result_q.client_initial_seq  <= upd.client_init_seq;
				result_q.server_initial_seq  <= upd.server_init_seq;
				result_q.client_expected_seq <= upd.client_next;
				result_q.server_expected_seq <= upd.server_next;
			end else begin
				result_q <= '{echo_index: idx_s1, default: '0};
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for tcp_connection_state_tracker_top: flow table updates per item.
// Depends on tcst_pkg and the tracker RTL; a scoreboard class mirrors the flow table.
module testbench;
	import tcst_pkg::*;

	localparam int STREAMS        = STREAMS_DEFAULT;
	localparam int RANDOM_ITEMS   = 650;
	localparam int WATCHDOG_LIMIT = 4 * STREAMS + 400;
	localparam int MAX_REPORTS    = 10;

	localparam logic [7:0] F_FIN = 8'(1 << FL_FIN_BIT);
	localparam logic [7:0] F_SYN = 8'(1 << FL_SYN_BIT);
	localparam logic [7:0] F_RST = 8'(1 << FL_RST_BIT);
	localparam logic [7:0] F_ACK = 8'(1 << FL_ACK_BIT);
	// flag bits the block ignores
	localparam logic [7:0] F_OTHER = 8'hE8;

	// mirror of the flow table plus the queue of reports it predicts
	class conn_checker;
		conn_state_t state_tbl[STREAMS];
		logic [31:0] cli_isn[STREAMS];
		logic [31:0] srv_isn[STREAMS];
		logic [31:0] cli_next[STREAMS];
		logic [31:0] srv_next[STREAMS];
		result_t     pending_reports[$];
		int          errors;
		int          checked;
		int          reached_est;
		int          reached_closing;

		function new();
			foreach (state_tbl[i]) begin
				state_tbl[i] = ST_CLOSED;
				cli_isn[i]   = '0;
				srv_isn[i]   = '0;
				cli_next[i]  = '0;
				srv_next[i]  = '0;
			end
			errors          = 0;
			checked         = 0;
			reached_est     = 0;
			reached_closing = 0;
		endfunction

		// work out the report for one accepted item and update the mirror
		function void take_item(cmd_t c);
			result_t     r;
			conn_state_t was;
			conn_state_t st;
			int unsigned i;
			logic [31:0] s;
			logic        syn;
			logic        ack;
			logic        fin;
			r            = '0;
			r.echo_index = c.stream_index;
			i            = c.stream_index;
			s            = c.seq_number;
			syn          = c.tcp_flags[FL_SYN_BIT];
			ack          = c.tcp_flags[FL_ACK_BIT];
			fin          = c.tcp_flags[FL_FIN_BIT];
			if (i < STREAMS) begin
				was = state_tbl[i];
				st  = was;
				if (c.op == OP_CLEAR) begin
					st          = ST_CLOSED;
					cli_isn[i]  = '0;
					srv_isn[i]  = '0;
					cli_next[i] = '0;
					srv_next[i] = '0;
				end else if (c.tcp_flags[FL_RST_BIT]) begin
					st = ST_CLOSED;
				end else begin
					case (st)
						ST_CLOSED: begin
							if (syn && !ack && c.from_client) begin
								cli_isn[i]  = s;
								cli_next[i] = s + 32'd1;
								st          = ST_SYN_RCVD;
							end
						end
						ST_SYN_RCVD: begin
							if (syn && ack && !c.from_client) begin
								srv_isn[i]  = s;
								srv_next[i] = s + 32'd1;
								st          = ST_ESTABLISHED;
							end else if (syn && c.from_client) begin
								cli_isn[i]  = s;
								cli_next[i] = s + 32'd1;
							end
						end
						ST_ESTABLISHED: begin
							if (fin)
								st = ST_FIN_RCVD;
							// sender's expected seq moves only when seq is not below it (unsigned)
							if (c.from_client) begin
								if (s >= cli_next[i])
									cli_next[i] = s + 32'd1;
							end else begin
								if (s >= srv_next[i])
									srv_next[i] = s + 32'd1;
							end
						end
						ST_FIN_RCVD: begin
							if (fin)
								st = ST_CLOSING;
						end
						default: ;
					endcase
				end
				state_tbl[i] = st;
				if (st == ST_ESTABLISHED && was != ST_ESTABLISHED)
					reached_est++;
				if (st == ST_CLOSING && was != ST_CLOSING)
					reached_closing++;
				r.prior_state         = was;
				r.new_state           = st;
				r.client_initial_seq  = cli_isn[i];
				r.server_initial_seq  = srv_isn[i];
				r.client_expected_seq = cli_next[i];
				r.server_expected_seq = srv_next[i];
			end
			pending_reports.push_back(r);
		endfunction

		function void flag_error(string what, logic [31:0] e, logic [31:0] a);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: mismatch %s: expected %h, got %h", $realtime, what, e, a);
		endfunction

		function void cmp_field(string what, logic [31:0] e, logic [31:0] a);
			if (e !== a)
				flag_error(what, e, a);
		endfunction

		// compare one report from the block with the oldest prediction
		function void check_report(result_t a);
			result_t e;
			if (pending_reports.size() == 0) begin
				flag_error("unexpected report, echo_index", '0, 32'(a.echo_index));
				return;
			end
			e = pending_reports.pop_front();
			checked++;
			cmp_field("echo_index", 32'(e.echo_index), 32'(a.echo_index));
			cmp_field("prior_state", 32'(e.prior_state), 32'(a.prior_state));
			cmp_field("new_state", 32'(e.new_state), 32'(a.new_state));
			cmp_field("client_initial_seq", e.client_initial_seq, a.client_initial_seq);
			cmp_field("server_initial_seq", e.server_initial_seq, a.server_initial_seq);
			cmp_field("client_expected_seq", e.client_expected_seq, a.client_expected_seq);
			cmp_field("server_expected_seq", e.server_expected_seq, a.server_expected_seq);
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    done;
	result_t result;

	conn_checker sb;
	int          items_taken;
	int          quiet_cycles;
	logic [9:0]  hot_flows[6];

	tcp_connection_state_tracker_top #(
		.STREAMS(STREAMS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// monitor: note accepted items, check each report
	always @(posedge clk) begin
		if (done === 1'b1)
			sb.check_report(result);
		if (start && busy === 1'b0) begin
			sb.take_item(cmd);
			items_taken++;
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: watchdog expired after %0d quiet cycles", quiet_cycles);
			$display("testbench: done, errors");
			$finish;
		end
	end

	// present one item and hold it until the block takes it
	task automatic send_item(cmd_t c);
		start <= 1'b1;
		cmd   <= c;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	task automatic send_seg(logic op, logic [9:0] idx, logic cli, logic [7:0] fl,
			logic [31:0] seq);
		cmd_t c;
		c.op           = op;
		c.stream_index = idx;
		c.from_client  = cli;
		c.tcp_flags    = fl;
		c.seq_number   = seq;
		send_item(c);
	endtask

	task automatic idle_for(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// mostly protocol-shaped segments on a few hot flows, with some noise
	function automatic cmd_t pick_item();
		cmd_t        c;
		int          kind;
		logic [31:0] base;
		kind          = $urandom_range(0, 99);
		c.op          = OP_SEGMENT;
		c.from_client = $urandom_range(0, 1);
		c.tcp_flags   = F_ACK | (8'($urandom) & F_OTHER);
		if ($urandom_range(0, 99) < 85)
			c.stream_index = hot_flows[$urandom_range(0, 5)];
		else
			c.stream_index = 10'($urandom);
		if (kind < 4) begin
			c.op        = OP_CLEAR;
			c.tcp_flags = 8'($urandom);
		end else if (kind < 9) begin
			c.tcp_flags = 8'($urandom) | F_RST;
		end else if (kind < 29) begin
			c.from_client = 1'b1;
			c.tcp_flags   = F_SYN | (8'($urandom) & (F_OTHER | F_FIN));
		end else if (kind < 44) begin
			c.from_client = 1'b0;
			c.tcp_flags   = F_SYN | F_ACK | (8'($urandom) & (F_OTHER | F_FIN));
		end else if (kind < 49) begin
			c.from_client = 1'b1;
			c.tcp_flags   = F_SYN | F_ACK | (8'($urandom) & F_OTHER);
		end else if (kind < 74) begin
			// data segment, flags already ACK plus ignored bits
		end else if (kind < 86) begin
			c.tcp_flags = c.tcp_flags | F_FIN;
		end else begin
			c.op        = $urandom_range(0, 7) == 0 ? OP_CLEAR : OP_SEGMENT;
			c.tcp_flags = 8'($urandom);
		end
		// seq around the sender's expected value, near the top of the range, or anywhere
		base = c.from_client ? sb.cli_next[c.stream_index] : sb.srv_next[c.stream_index];
		case ($urandom_range(0, 3))
			0: c.seq_number = $urandom;
			1: c.seq_number = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
			default: c.seq_number = base + 32'($urandom_range(0, 6)) - 32'd3;
		endcase
		return c;
	endfunction

	initial begin
		int burst;
		sb           = new();
		items_taken  = 0;
		quiet_cycles = 0;
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		hot_flows[0] = 10'd0;
		hot_flows[1] = 10'h3FF;
		hot_flows[2] = 10'd1;
		hot_flows[3] = 10'h200;
		hot_flows[4] = 10'($urandom);
		hot_flows[5] = 10'($urandom);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full life of flow 0, with wraps and ignored segments
		send_seg(OP_CLEAR, 10'h3FF, 1'b0, 8'h00, 32'h0);
		send_seg(OP_SEGMENT, 10'd0, 1'b1, F_SYN | F_ACK, 32'h1111_1111);
		send_seg(OP_SEGMENT, 10'd0, 1'b0, F_SYN, 32'h2222_2222);
		send_seg(OP_SEGMENT, 10'd0, 1'b1, F_SYN, 32'hFFFF_FFFF);
		send_seg(OP_SEGMENT, 10'd0, 1'b1, F_SYN | F_ACK, 32'h1234_5678);
		send_seg(OP_SEGMENT, 10'd0, 1'b0, F_SYN, 32'h3333_3333);
		send_seg(OP_SEGMENT, 10'd0, 1'b0, F_SYN | F_ACK, 32'hFFFF_FFFE);
		send_seg(OP_SEGMENT, 10'd0, 1'b1, F_ACK, 32'h1234_5678);
		send_seg(OP_SEGMENT, 10'd0, 1'b1, F_ACK, 32'h1234_5679);
		send_seg(OP_SEGMENT, 10'd0, 1'b0, F_ACK, 32'h0);
		send_seg(OP_SEGMENT, 10'd0, 1'b0, F_ACK, 32'hFFFF_FFFF);
		send_seg(OP_SEGMENT, 10'd0, 1'b1, F_FIN | F_ACK, 32'h2000_0000);
		send_seg(OP_SEGMENT, 10'd0, 1'b0, F_ACK, 32'h4000_0000);
		send_seg(OP_SEGMENT, 10'd0, 1'b0, F_FIN | F_ACK, 32'h5000_0000);
		send_seg(OP_SEGMENT, 10'd0, 1'b1, F_FIN, 32'h6000_0000);
		send_seg(OP_SEGMENT, 10'd0, 1'b0, F_RST, 32'h0);
		// top flow: clear from a live state ignores every other field
		send_seg(OP_SEGMENT, 10'h3FF, 1'b1, F_SYN | F_FIN | F_OTHER, 32'hAAAA_AAAA);
		send_seg(OP_CLEAR, 10'h3FF, 1'b1, 8'hFF, 32'hFFFF_FFFF);
		send_seg(OP_SEGMENT, 10'h3FF, 1'b1, 8'hFF, 32'h5555_5555);
		idle_for(3);
		send_seg(OP_SEGMENT, 10'h2AA, 1'b1, F_SYN, 32'h5555_5555);
		idle_for(1);
		send_seg(OP_SEGMENT, 10'h2AA, 1'b0, F_SYN | F_ACK, 32'hAAAA_AAAA);
		send_seg(OP_SEGMENT, 10'h2AA, 1'b0, F_RST | F_ACK, 32'h0);

		// random part in bursts with random gaps
		burst = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 20);
				idle_for($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
			end
			send_item(pick_item());
			burst--;
		end
		start <= 1'b0;

		// drain outstanding reports, then allow for any late strays
		while (sb.pending_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.pending_reports.size() != 0)
			sb.errors += sb.pending_reports.size();

		$display("testbench: %0d items in, %0d reports checked, %0d mismatches",
			items_taken, sb.checked, sb.errors);
		$display("testbench: %0d flows set up, %0d reached CLOSING",
			sb.reached_est, sb.reached_closing);
		if (sb.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
